[rtl/core/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/ccbp_pkg.sv]
// shared types, constants and helper functions of the bezier path block
package ccbp_pkg;

    // fixed-point layout
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 16;
    localparam int TIME_W    = FRAC_BITS + 1;
    localparam int W_W       = FRAC_BITS + 2;
    localparam int OP_W      = (W_W > COORD_W) ? W_W : COORD_W;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int THR_W     = TIME_W + 10;
    localparam int CNT_W     = 4;
    localparam int MUL_STEPS = 14;

    typedef logic [COORD_W-1:0] coord_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LIMIT_X   = 2'd0,
        CFG_LIMIT_Y   = 2'd1,
        CFG_TIME_STEP = 2'd2
    } cfg_reg_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_PREP   = 5'b00100,
        S_MUL    = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    // products issued to the shared multiplier, in order
    typedef enum logic [CNT_W-1:0] {
        MS_UU = 4'd0,
        MS_TT = 4'd1,
        MS_W0 = 4'd2,
        MS_W1 = 4'd3,
        MS_W2 = 4'd4,
        MS_W3 = 4'd5,
        MS_X0 = 4'd6,
        MS_X1 = 4'd7,
        MS_X2 = 4'd8,
        MS_X3 = 4'd9,
        MS_Y0 = 4'd10,
        MS_Y1 = 4'd11,
        MS_Y2 = 4'd12,
        MS_Y3 = 4'd13
    } mul_step_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      update;
        logic      prep;
        logic      mul_issue;
        mul_step_t mul_step;
        logic      out_load;
        logic      out_from_end;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic near_end;
        logic out_free;
    } status_t;

    // clamp a random coordinate to limit minus one, zero limit acts as one
    function automatic coord_t sat_coord(input coord_t r, input coord_t lim);
        coord_t top;
        top = (lim == '0) ? '0 : lim - coord_t'(1);
        return (r > top) ? top : r;
    endfunction

    // truncated midpoint without overflow
    function automatic coord_t mid_coord(input coord_t a, input coord_t b);
        coord_t lo;
        coord_t hi;
        coord_t diff;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        diff = hi - lo;
        return lo + (diff >> 1);
    endfunction

endpackage

[rtl/core/ccbp_ctrl.sv]
// controller state machine sequencing one path item
module ccbp_ctrl
    import ccbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             from_end_reg;
    logic             from_end_next;
    logic             accept;

    // take a new item only when idle
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        from_end_next    = from_end_reg;
        cmd              = '0;
        cmd.capture      = accept;
        cmd.mul_step     = mul_step_t'(cnt_reg);
        cmd.out_from_end = from_end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.is_start ? S_IDLE : S_PREP;
            end
            S_PREP:
            begin
                cmd.prep      = 1'b1;
                from_end_next = status.near_end;
                cnt_next      = '0;
                state_next    = status.near_end ? S_OUT : S_MUL;
            end
            S_MUL:
            begin
                // last count lets the final product drain into the accumulator
                if (cnt_reg == CNT_W'(MUL_STEPS))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mul_issue = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            from_end_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            from_end_reg <= from_end_next;
        end
    end

endmodule

[rtl/core/ccbp_datapath.sv]
// curve state, shared multiplier, accumulators and output register
module ccbp_datapath
    import ccbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  coord_t  limit_x,
    input  coord_t  limit_y,
    input  coord_t  time_step,
    input  logic    op,
    input  coord_t  pos_x,
    input  coord_t  pos_y,
    input  coord_t  rand_a_x,
    input  coord_t  rand_a_y,
    input  coord_t  rand_b_x,
    input  coord_t  rand_b_y,
    input  coord_t  rand_c_x,
    input  coord_t  rand_c_y,
    output logic    dest_valid,
    input  logic    dest_stall,
    output coord_t  dest_x,
    output coord_t  dest_y,
    output logic    new_segment
);

    localparam logic [TIME_W-1:0] ONE = TIME_W'(1) << FRAC_BITS;

    // captured item, random points already clamped
    logic   op_reg;
    coord_t pos_x_reg, pos_y_reg;
    coord_t ra_x_reg, ra_y_reg, rb_x_reg, rb_y_reg, rc_x_reg, rc_y_reg;

    // curve state
    coord_t seg_start_x_reg, seg_start_y_reg;
    coord_t pull_a_x_reg, pull_a_y_reg;
    coord_t pull_b_x_reg, pull_b_y_reg;
    coord_t seg_end_x_reg, seg_end_y_reg;
    coord_t look_x_reg, look_y_reg;
    logic [TIME_W-1:0] curve_time_reg;
    logic              new_seg_reg;

    // weight evaluation
    logic [TIME_W-1:0] u_reg, u2_reg, t2_reg;
    logic [W_W-1:0]    w0_reg, w1_reg, w2_reg, w3_reg;
    logic [OP_W-1:0]   op_a, op_b;
    logic [PROD_W-1:0] prod_comb, prod_reg, prod_shr, prod_tri;
    mul_step_t         pend_step_reg;
    logic              pend_valid_reg;
    logic [ACC_W-1:0]  acc_x_reg, acc_y_reg;

    // output register
    logic   dest_valid_reg;
    coord_t dest_x_reg, dest_y_reg;
    logic   new_segment_reg;

    // update helpers
    logic                   chain;
    coord_t                 mid_x, mid_y;
    logic [COORD_W+FRAC_BITS-1:0] step_full;
    logic [TIME_W-1:0]      step, t_base, curve_time_next;
    logic [TIME_W:0]        t_sum;
    logic [THR_W-1:0]       thr_lhs, thr_rhs;

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            ra_x_reg  <= sat_coord(rand_a_x, limit_x);
            ra_y_reg  <= sat_coord(rand_a_y, limit_y);
            rb_x_reg  <= sat_coord(rand_b_x, limit_x);
            rb_y_reg  <= sat_coord(rand_b_y, limit_y);
            rc_x_reg  <= sat_coord(rand_c_x, limit_x);
            rc_y_reg  <= sat_coord(rand_c_y, limit_y);
        end
    end

    // segment chaining and time advance
    assign chain     = (pos_x_reg == seg_end_x_reg) && (pos_y_reg == seg_end_y_reg);
    assign mid_x     = mid_coord(rb_x_reg, rc_x_reg);
    assign mid_y     = mid_coord(rb_y_reg, rc_y_reg);
    assign step_full = {time_step, {FRAC_BITS{1'b0}}};
    assign step      = TIME_W'(step_full[COORD_W+FRAC_BITS-1:COORD_W]);
    assign t_base    = chain ? '0 : curve_time_reg;
    assign t_sum     = {1'b0, t_base} + {1'b0, step};
    assign curve_time_next = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_start_x_reg <= '0;
            seg_start_y_reg <= '0;
            pull_a_x_reg    <= '0;
            pull_a_y_reg    <= '0;
            pull_b_x_reg    <= '0;
            pull_b_y_reg    <= '0;
            seg_end_x_reg   <= '0;
            seg_end_y_reg   <= '0;
            look_x_reg      <= '0;
            look_y_reg      <= '0;
            curve_time_reg  <= '0;
            new_seg_reg     <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (!op_reg || chain)
            begin
                seg_start_x_reg <= op_reg ? seg_end_x_reg : pos_x_reg;
                seg_start_y_reg <= op_reg ? seg_end_y_reg : pos_y_reg;
                pull_a_x_reg    <= op_reg ? look_x_reg : ra_x_reg;
                pull_a_y_reg    <= op_reg ? look_y_reg : ra_y_reg;
                pull_b_x_reg    <= rb_x_reg;
                pull_b_y_reg    <= rb_y_reg;
                look_x_reg      <= rc_x_reg;
                look_y_reg      <= rc_y_reg;
                seg_end_x_reg   <= mid_x;
                seg_end_y_reg   <= mid_y;
            end
            curve_time_reg <= op_reg ? curve_time_next : '0;
            new_seg_reg    <= op_reg && chain;
        end
    end

    // end-of-segment test, exact form of t >= 0.999
    assign thr_lhs = THR_W'(curve_time_reg) * THR_W'(1000);
    assign thr_rhs = THR_W'(999) << FRAC_BITS;

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_step)
            MS_UU: begin op_a = OP_W'(u_reg);  op_b = OP_W'(u_reg);          end
            MS_TT: begin op_a = OP_W'(curve_time_reg); op_b = OP_W'(curve_time_reg); end
            MS_W0: begin op_a = OP_W'(u2_reg); op_b = OP_W'(u_reg);          end
            MS_W1: begin op_a = OP_W'(u2_reg); op_b = OP_W'(curve_time_reg); end
            MS_W2: begin op_a = OP_W'(u_reg);  op_b = OP_W'(t2_reg);         end
            MS_W3: begin op_a = OP_W'(t2_reg); op_b = OP_W'(curve_time_reg); end
            MS_X0: begin op_a = OP_W'(w0_reg); op_b = OP_W'(seg_start_x_reg); end
            MS_X1: begin op_a = OP_W'(w1_reg); op_b = OP_W'(pull_a_x_reg);   end
            MS_X2: begin op_a = OP_W'(w2_reg); op_b = OP_W'(pull_b_x_reg);   end
            MS_X3: begin op_a = OP_W'(w3_reg); op_b = OP_W'(seg_end_x_reg);  end
            MS_Y0: begin op_a = OP_W'(w0_reg); op_b = OP_W'(seg_start_y_reg); end
            MS_Y1: begin op_a = OP_W'(w1_reg); op_b = OP_W'(pull_a_y_reg);   end
            MS_Y2: begin op_a = OP_W'(w2_reg); op_b = OP_W'(pull_b_y_reg);   end
            MS_Y3: begin op_a = OP_W'(w3_reg); op_b = OP_W'(seg_end_y_reg);  end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_comb = PROD_W'(op_a) * PROD_W'(op_b);
    assign prod_shr  = prod_reg >> FRAC_BITS;
    assign prod_tri  = (prod_shr << 1) + prod_shr;

    // multiplier output register, tagged with its step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_step_reg  <= MS_UU;
        end
        else
        begin
            pend_valid_reg <= cmd.mul_issue;
            pend_step_reg  <= cmd.mul_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            prod_reg <= prod_comb;
        end
    end

    // load u and clear the accumulators on prep, else retire each product into its register or accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            u_reg     <= ONE - curve_time_reg;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (pend_valid_reg)
        begin
            case (pend_step_reg)
                MS_UU: u2_reg <= TIME_W'(prod_shr);
                MS_TT: t2_reg <= TIME_W'(prod_shr);
                MS_W0: w0_reg <= W_W'(prod_shr);
                MS_W1: w1_reg <= W_W'(prod_tri);
                MS_W2: w2_reg <= W_W'(prod_tri);
                MS_W3: w3_reg <= W_W'(prod_shr);
                MS_X0, MS_X1, MS_X2, MS_X3: acc_x_reg <= acc_x_reg + ACC_W'(prod_reg);
                MS_Y0, MS_Y1, MS_Y2, MS_Y3: acc_y_reg <= acc_y_reg + ACC_W'(prod_reg);
                default: acc_x_reg <= acc_x_reg;
            endcase
        end
    end

    // output register, freed by a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            dest_valid_reg <= 1'b1;
        end
        else if (dest_valid_reg && !dest_stall)
        begin
            dest_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dest_x_reg      <= cmd.out_from_end ? seg_end_x_reg
                                                : acc_x_reg[FRAC_BITS +: COORD_W];
            dest_y_reg      <= cmd.out_from_end ? seg_end_y_reg
                                                : acc_y_reg[FRAC_BITS +: COORD_W];
            new_segment_reg <= new_seg_reg;
        end
    end

    assign dest_valid  = dest_valid_reg;
    assign dest_x      = dest_x_reg;
    assign dest_y      = dest_y_reg;
    assign new_segment = new_segment_reg;

    // status back to the controller
    assign status.is_start = !op_reg;
    assign status.near_end = (thr_lhs >= thr_rhs);
    assign status.out_free = !dest_valid_reg || !dest_stall;

endmodule

[rtl/core/chained_cubic_bezier_path.sv]
// Chained cubic Bezier path generator. A start item (op 0) loads a new path and
// gives no result; a next item (op 1) chains a new segment when the position
// equals the segment end, advances curve time by time_step and gives one
// destination point. A start item only passes through the update state; a next
// item goes straight to output when the curve is at its end (t >= 0.999),
// otherwise it first sequences fourteen products through one shared
// 18x18 multiplier (six for the Bernstein weights, eight for the point) and
// then retires the last product. A finished result sits in an output
// register, so the next item is taken while it waits. Configuration writes
// are always ready and must only be made while the block is idle.
module chained_cubic_bezier_path
    import ccbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        op,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] rand_a_x,
    input  logic [15:0] rand_a_y,
    input  logic [15:0] rand_b_x,
    input  logic [15:0] rand_b_y,
    input  logic [15:0] rand_c_x,
    input  logic [15:0] rand_c_y,
    // result channel
    output logic        dest_valid,
    input  logic        dest_stall,
    output logic [15:0] dest_x,
    output logic [15:0] dest_y,
    output logic        new_segment
);

`include "assert_macros.svh"

    coord_t  limit_x_reg, limit_y_reg, time_step_reg;
    cmd_t    cmd;
    status_t status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg   <= 16'd65535;
            limit_y_reg   <= 16'd65535;
            time_step_reg <= 16'd655;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LIMIT_X:   limit_x_reg   <= cfg_data;
                CFG_LIMIT_Y:   limit_y_reg   <= cfg_data;
                CFG_TIME_STEP: time_step_reg <= cfg_data;
                default:       limit_x_reg   <= limit_x_reg;
            endcase
        end
    end

    // controller
    ccbp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath
    ccbp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .limit_x     (limit_x_reg),
        .limit_y     (limit_y_reg),
        .time_step   (time_step_reg),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rand_a_x    (rand_a_x),
        .rand_a_y    (rand_a_y),
        .rand_b_x    (rand_b_x),
        .rand_b_y    (rand_b_y),
        .rand_c_x    (rand_c_x),
        .rand_c_y    (rand_c_y),
        .dest_valid  (dest_valid),
        .dest_stall  (dest_stall),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .new_segment (new_segment)
    );

    // block is busy right after taking an item
    `ASSERT_NEXT(a_busy_after_transfer, item_valid && !item_stall, item_stall)
    // a new result appears only as an item finishes
    `ASSERT_IMPLY(a_result_from_work, $rose(dest_valid), $past(item_stall))
    // output register is never overwritten while still held
    `ASSERT_IMPLY(a_load_when_free, cmd.out_load, !dest_valid || !dest_stall)

endmodule
